// File: sv/bdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// shared types and constants of the bounded deque with insert and reverse
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int unsigned DEPTH_DEF = 16;

	localparam int unsigned OP_W      = 3;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned POS_W     = 5;
	localparam int unsigned ST_W      = 2;
	localparam int unsigned CNT_OUT_W = 5;

	localparam int unsigned IN_W  = 40;
	localparam int unsigned OUT_W = 40;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_INSERT     = 3'd4,
		OP_REVERSE    = 3'd5
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_BADPOS = 2'd3
	} st_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_SHIFT,
		S_SHWR,
		S_FIN
	} state_t;

	// logical index select for the address unit
	typedef enum logic [2:0] {
		L_ZERO,
		L_CNT,
		L_CNT_M1,
		L_IDX,
		L_IDX_M1,
		L_PRE
	} lsel_t;

	// head pointer update
	typedef enum logic [1:0] {
		HD_HOLD,
		HD_PRE,
		HD_NXT,
		HD_REV
	} hd_t;

	typedef struct packed {
		logic  load;
		logic  ram_we;
		logic  ram_re;
		logic  wd_rdata;
		lsel_t lsel;
		hd_t   hd;
		logic  cnt_inc;
		logic  cnt_dec;
		logic  idx_load;
		logic  idx_dec;
		logic  set_res;
		st_t   res_st;
		logic  take_pop;
		logic  out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic full;
		logic empty;
		logic badpos;
		logic at_idx;
		logic gt1;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

// File: sv/bdq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bdq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: sv/bdq_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_dp
// datapath: circular word store with head pointer and direction flag,
// count, shift index, result and output registers
// ----------------------------------------------------------------------------
module bdq_dp #(
	parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [bdq_pkg::IN_W-1:0]   s_tdata,
	input  wire bdq_pkg::cmd_t              cmd,
	output bdq_pkg::stat_t                  stat,
	input  wire logic                       m_tready,
	output logic                            m_tvalid,
	output logic      [bdq_pkg::OUT_W-1:0]  m_tdata
);

	import bdq_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;
	localparam int unsigned SW = AW + 2;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	op_t               op_q;
	logic [DATA_W-1:0] val_q;
	logic [POS_W-1:0]  pos_q;
	logic [AW-1:0]     head_q;
	logic              dir_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     idx_q;
	logic [DATA_W-1:0] res_val_q;
	st_t               res_st_q;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	logic [CW-1:0]     lidx;
	logic [SW-1:0]     sum;
	logic [SW-1:0]     diff;
	logic [AW-1:0]     phys;
	logic [AW-1:0]     head_inc;
	logic [AW-1:0]     head_dec;
	logic [AW-1:0]     front_pre;
	logic [AW-1:0]     front_nxt;
	logic [AW-1:0]     addr;
	logic [DATA_W-1:0] rdata;
	logic [DATA_W-1:0] wdata;
	logic [PW-1:0]     at_pw;

	// logical to physical index
	always_comb begin
		case (cmd.lsel)
			L_CNT:    lidx = cnt_q;
			L_CNT_M1: lidx = cnt_q - CW'(1);
			L_IDX:    lidx = idx_q;
			L_IDX_M1: lidx = idx_q - CW'(1);
			default:  lidx = '0;
		endcase
		sum = SW'(head_q) + SW'(lidx);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		diff = SW'(head_q) - SW'(lidx);
		if (SW'(head_q) < SW'(lidx)) begin
			diff = diff + SW'(DEPTH);
		end
		phys = dir_q ? AW'(diff) : AW'(sum);
	end

	assign head_inc  = (head_q == LAST) ? '0 : head_q + AW'(1);
	assign head_dec  = (head_q == '0) ? LAST : head_q - AW'(1);
	assign front_pre = dir_q ? head_inc : head_dec;
	assign front_nxt = dir_q ? head_dec : head_inc;
	assign addr      = (cmd.lsel == L_PRE) ? front_pre : phys;
	assign wdata     = cmd.wd_rdata ? rdata : val_q;

	bdq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.ram_we),
		.waddr (addr),
		.wdata (wdata),
		.re    (cmd.ram_re),
		.raddr (addr),
		.rdata (rdata)
	);

	assign at_pw = (pos_q == '0) ? PW'(1) : PW'(pos_q);

	always_comb begin
		stat.op       = op_q;
		stat.full     = (cnt_q == CW'(DEPTH));
		stat.empty    = (cnt_q == '0);
		stat.badpos   = (cnt_q == '0) || (PW'(pos_q) > PW'(cnt_q));
		stat.at_idx   = (PW'(idx_q) == at_pw);
		stat.gt1      = (cnt_q > CW'(1));
		stat.out_free = !m_tvalid_q || m_tready;
	end

	// input beat capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(s_tdata[2:0]);
			val_q <= s_tdata[34:3];
			pos_q <= s_tdata[39:35];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			dir_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			case (cmd.hd)
				HD_PRE:  head_q <= front_pre;
				HD_NXT:  head_q <= front_nxt;
				HD_REV: begin
					head_q <= addr;
					dir_q  <= ~dir_q;
				end
				default: ;
			endcase
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.idx_load) begin
			idx_q <= cnt_q;
		end else if (cmd.idx_dec) begin
			idx_q <= idx_q - CW'(1);
		end
		if (cmd.set_res) begin
			res_val_q <= '0;
			res_st_q  <= cmd.res_st;
		end else if (cmd.take_pop) begin
			res_val_q <= rdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= {1'b0, CNT_OUT_W'(cnt_q), res_st_q, res_val_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

// File: sv/bdq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ctrl
// controller: sequences one operation at a time over the datapath
// ----------------------------------------------------------------------------
module bdq_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire bdq_pkg::stat_t stat,
	output bdq_pkg::cmd_t       cmd
);

	import bdq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d     = S_FIN;
				cmd.set_res = 1'b1;
				cmd.res_st  = ST_OK;
				case (stat.op)
					OP_PUSH_FRONT: begin
						if (stat.full) begin
							cmd.res_st = ST_FULL;
						end else begin
							cmd.ram_we  = 1'b1;
							cmd.lsel    = L_PRE;
							cmd.hd      = HD_PRE;
							cmd.cnt_inc = 1'b1;
						end
					end
					OP_PUSH_BACK: begin
						if (stat.full) begin
							cmd.res_st = ST_FULL;
						end else begin
							cmd.ram_we  = 1'b1;
							cmd.lsel    = L_CNT;
							cmd.cnt_inc = 1'b1;
						end
					end
					OP_POP_FRONT: begin
						if (stat.empty) begin
							cmd.res_st = ST_EMPTY;
						end else begin
							cmd.ram_re  = 1'b1;
							cmd.lsel    = L_ZERO;
							cmd.hd      = HD_NXT;
							cmd.cnt_dec = 1'b1;
							state_d     = S_POP;
						end
					end
					OP_POP_BACK: begin
						if (stat.empty) begin
							cmd.res_st = ST_EMPTY;
						end else begin
							cmd.ram_re  = 1'b1;
							cmd.lsel    = L_CNT_M1;
							cmd.cnt_dec = 1'b1;
							state_d     = S_POP;
						end
					end
					OP_INSERT: begin
						if (stat.badpos) begin
							cmd.res_st = ST_BADPOS;
						end else if (stat.full) begin
							cmd.res_st = ST_FULL;
						end else begin
							cmd.idx_load = 1'b1;
							state_d      = S_SHIFT;
						end
					end
					OP_REVERSE: begin
						if (stat.gt1) begin
							cmd.lsel = L_CNT_M1;
							cmd.hd   = HD_REV;
						end
					end
					default: ;
				endcase
			end
			S_POP: begin
				cmd.take_pop = 1'b1;
				state_d      = S_FIN;
			end
			S_SHIFT: begin
				if (stat.at_idx) begin
					cmd.ram_we  = 1'b1;
					cmd.lsel    = L_IDX;
					cmd.cnt_inc = 1'b1;
					state_d     = S_FIN;
				end else begin
					cmd.ram_re = 1'b1;
					cmd.lsel   = L_IDX_M1;
					state_d    = S_SHWR;
				end
			end
			S_SHWR: begin
				cmd.ram_we   = 1'b1;
				cmd.wd_rdata = 1'b1;
				cmd.lsel     = L_IDX;
				cmd.idx_dec  = 1'b1;
				state_d      = S_SHIFT;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// File: sv/bounded_deque_with_insert_reverse_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque_with_insert_reverse_core
// bounded double-ended list of signed words with positional insert and reverse
// ----------------------------------------------------------------------------
// input stream s_*: one beat per command (opcode, value, position)
// output stream m_*: one beat per command (removed value, status, count after)
// words sit in a circular ram with a head pointer and a direction flag, so
// push, pop and reverse touch at most one ram entry
// steps per command from the accept to the load of the result register; the
// result beat and the next accept follow in the cycle after that load:
//   push, reverse, unused opcodes, any error: accept, execute, finish
//   pop: accept, execute with a ram read, take the registered read, finish
//   insert: accept, execute, a read and a write through the single ram port
//   pair per word moved (count - max(position,1) words), new word, finish
// the next command is taken once the current one has left the controller
// a finished result waits in the output register while the next command runs;
// if the receiver still stalls when that command finishes, the controller
// holds and s_tready stays low until the output register is free
// reset empties the list and clears the output valid flag; ram contents are
// left as they are and only entries below the count are ever read
// ----------------------------------------------------------------------------
module bounded_deque_with_insert_reverse_core #(
	parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// opcode[2:0], value[34:3], position[39:35]
	input  wire logic [bdq_pkg::IN_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	// removed_value[31:0], status[33:32], count_after[38:34], zero[39]
	output logic      [bdq_pkg::OUT_W-1:0] m_tdata
);

	import bdq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	bdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bdq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.stat     (stat),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire

// File: sv/bdq_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_chk
// port-level checks of the deque core, bound to the top level
// ----------------------------------------------------------------------------
module bdq_chk #(
	parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      m_tvalid,
	input wire logic                      m_tready,
	input wire logic [bdq_pkg::OUT_W-1:0] m_tdata
);

	import bdq_pkg::*;

	logic [ST_W-1:0]      st;
	logic [CNT_OUT_W-1:0] cnt;

	assign st  = m_tdata[33:32];
	assign cnt = m_tdata[38:34];

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped under stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result beat changed under stall");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (st == ST_OK) || (m_tdata[31:0] == '0))
		else $error("failed command returned a nonzero word");

	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st == ST_EMPTY) |-> (cnt == '0))
		else $error("empty status with nonzero count");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st == ST_FULL) |-> (cnt == CNT_OUT_W'(DEPTH)))
		else $error("full status without full count");

endmodule

bind bounded_deque_with_insert_reverse_core bdq_chk #(
	.DEPTH (DEPTH)
) u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
